/* src/i2cmrw_pkg.sv */
`timescale 1ns / 1ps

package i2cmrw_pkg;

   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_RECOVER = 2'd2;

   localparam logic [1:0] STEP_TARGET   = 2'd0;
   localparam logic [1:0] STEP_ADDRESS  = 2'd1;
   localparam logic [1:0] STEP_DATA     = 2'd2;
   localparam logic [1:0] STEP_RECOVERY = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_STUCK_LOW = 2'd1;
   localparam logic [1:0] STATUS_NO_LOW    = 2'd2;
   localparam logic [1:0] STATUS_NACK      = 2'd3;

   localparam logic [15:0] DELAY_TICKS_RESET = 16'd10;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   localparam logic [2:0] UNITS_ONE   = 3'd1;
   localparam logic [2:0] UNITS_TWO   = 3'd2;
   localparam logic [2:0] UNITS_THREE = 3'd3;
   localparam logic [2:0] UNITS_FOUR  = 3'd4;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_WRITE,
      KIND_RECOVER
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_CHK1,
      PH_CHK2,
      PH_HOLD,
      PH_PRE,
      PH_BLOW,
      PH_BDATA,
      PH_BHIGH,
      PH_ALOW,
      PH_AREL,
      PH_AHIGH,
      PH_ATAIL,
      PH_SA,
      PH_SB,
      PH_SC,
      PH_SD,
      PH_RINIT,
      PH_RLOW,
      PH_RHIGH,
      PH_RGAP
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] target_byte;
      logic [7:0] reg_address;
      logic [7:0] data_byte;
      logic       sda_in;
   } entry_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } result_type;

endpackage

/* src/i2cmrw_if.sv */
`timescale 1ns / 1ps

interface i2cmrw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] target_byte;
   logic [7:0] reg_address;
   logic [7:0] data_byte;
   logic       sda_in;

   modport source (output valid, mode, target_byte, reg_address, data_byte, sda_in,
                   input ready);
   modport sink (input valid, mode, target_byte, reg_address, data_byte, sda_in,
                 output ready);
endinterface

interface i2cmrw_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, status,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, status,
                 output ready);
endinterface

interface i2cmrw_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] delay_ticks;

   modport source (output valid, delay_ticks, input ready);
   modport sink (input valid, delay_ticks, output ready);
endinterface

/* src/i2cmrw_front.sv */
`timescale 1ns / 1ps

module i2cmrw_front (
   i2cmrw_req_if.sink            req_bus,
   input  logic                  push_ready,
   output logic                  push_valid,
   output i2cmrw_pkg::entry_type push_entry
);

   i2cmrw_pkg::kind_type kind;

   always_comb begin
      unique case (req_bus.mode)
         i2cmrw_pkg::MODE_WRITE:   kind = i2cmrw_pkg::KIND_WRITE;
         i2cmrw_pkg::MODE_RECOVER: kind = i2cmrw_pkg::KIND_RECOVER;
         default:                  kind = i2cmrw_pkg::KIND_TICK;
      endcase
   end

   assign push_valid              = req_bus.valid;
   assign req_bus.ready           = push_ready;
   assign push_entry.kind         = kind;
   assign push_entry.target_byte  = req_bus.target_byte;
   assign push_entry.reg_address  = req_bus.reg_address;
   assign push_entry.data_byte    = req_bus.data_byte;
   assign push_entry.sda_in       = req_bus.sda_in;

endmodule

/* src/i2cmrw_queue.sv */
`timescale 1ns / 1ps

module i2cmrw_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  i2cmrw_pkg::entry_type push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output i2cmrw_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   i2cmrw_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/i2cmrw_back.sv */
`timescale 1ns / 1ps

module i2cmrw_back #(
   parameter int RECOVERY_ROUNDS = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [15:0]           csr_delay_ticks,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  i2cmrw_pkg::entry_type pop_entry,
   output logic                  out_valid,
   input  logic                  out_ready,
   output i2cmrw_pkg::result_type out_word
);

   localparam logic [3:0] ROUNDS = 4'(RECOVERY_ROUNDS);

   i2cmrw_pkg::phase_type phase_ff, phase_in, enter_ph;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [1:0]  step_ff, step_in;
   logic [15:0] delay_count_ff, delay_count_in;
   logic [2:0]  units_ff, units_in;
   logic [7:0]  address_ff, address_in;
   logic [7:0]  data_ff, data_in;
   logic [3:0]  round_ff, round_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] delay_ticks_ff;
   logic        out_valid_ff;
   i2cmrw_pkg::result_type out_word_ff, out_word_in;
   logic [15:0] unit_len;
   logic        enter_en;
   logic        done;
   logic        fire;
   logic        sda;

   assign fire      = pop_valid && (!out_valid_ff || out_ready);
   assign pop_ready = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign unit_len  = (delay_ticks_ff == '0) ? 16'd1 : delay_ticks_ff;
   assign sda       = pop_entry.sda_in;

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      step_in        = step_ff;
      delay_count_in = delay_count_ff;
      units_in       = units_ff;
      address_in     = address_ff;
      data_in        = data_ff;
      round_in       = round_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      status_in      = status_ff;
      done           = 1'b0;
      enter_en       = 1'b0;
      enter_ph       = i2cmrw_pkg::PH_IDLE;

      if (phase_ff == i2cmrw_pkg::PH_IDLE) begin
         unique case (pop_entry.kind)
            i2cmrw_pkg::KIND_WRITE: begin
               shift_in     = pop_entry.target_byte;
               address_in   = pop_entry.reg_address;
               data_in      = pop_entry.data_byte;
               step_in      = i2cmrw_pkg::STEP_TARGET;
               bit_count_in = '0;
               status_in    = i2cmrw_pkg::STATUS_OK;
               enter_en     = 1'b1;
               enter_ph     = i2cmrw_pkg::PH_CHK1;
            end
            i2cmrw_pkg::KIND_RECOVER: begin
               step_in   = i2cmrw_pkg::STEP_RECOVERY;
               round_in  = '0;
               status_in = i2cmrw_pkg::STATUS_OK;
               enter_en  = 1'b1;
               enter_ph  = i2cmrw_pkg::PH_RINIT;
            end
            default: ;
         endcase
      end else if (delay_count_ff > 16'd1) begin
         delay_count_in = delay_count_ff - 16'd1;
      end else if (units_ff > i2cmrw_pkg::UNITS_ONE) begin
         units_in       = units_ff - 3'd1;
         delay_count_in = unit_len;
      end else begin
         enter_en = 1'b1;
         unique case (phase_ff)
            i2cmrw_pkg::PH_CHK1: begin
               if (!sda) begin
                  enter_en  = 1'b0;
                  done      = 1'b1;
                  status_in = i2cmrw_pkg::STATUS_STUCK_LOW;
               end else begin
                  enter_ph = i2cmrw_pkg::PH_CHK2;
               end
            end
            i2cmrw_pkg::PH_CHK2: begin
               if (sda) begin
                  enter_en  = 1'b0;
                  done      = 1'b1;
                  status_in = i2cmrw_pkg::STATUS_NO_LOW;
               end else begin
                  enter_ph = i2cmrw_pkg::PH_HOLD;
               end
            end
            i2cmrw_pkg::PH_HOLD: enter_ph = i2cmrw_pkg::PH_PRE;
            i2cmrw_pkg::PH_PRE: begin
               bit_count_in = '0;
               enter_ph     = i2cmrw_pkg::PH_BLOW;
            end
            i2cmrw_pkg::PH_BLOW:  enter_ph = i2cmrw_pkg::PH_BDATA;
            i2cmrw_pkg::PH_BDATA: enter_ph = i2cmrw_pkg::PH_BHIGH;
            i2cmrw_pkg::PH_BHIGH: begin
               bit_count_in = bit_count_ff + 4'd1;
               enter_ph     = (bit_count_in < i2cmrw_pkg::BITS_PER_BYTE) ?
                              i2cmrw_pkg::PH_BLOW : i2cmrw_pkg::PH_ALOW;
            end
            i2cmrw_pkg::PH_ALOW: enter_ph = i2cmrw_pkg::PH_AREL;
            i2cmrw_pkg::PH_AREL: enter_ph = i2cmrw_pkg::PH_AHIGH;
            i2cmrw_pkg::PH_AHIGH: begin
               if (step_ff == i2cmrw_pkg::STEP_TARGET && sda) begin
                  status_in = i2cmrw_pkg::STATUS_NACK;
               end
               enter_ph = i2cmrw_pkg::PH_ATAIL;
            end
            i2cmrw_pkg::PH_ATAIL: begin
               if (step_ff == i2cmrw_pkg::STEP_TARGET) begin
                  if (status_ff == i2cmrw_pkg::STATUS_NACK) begin
                     enter_ph = i2cmrw_pkg::PH_SA;
                  end else begin
                     shift_in = address_ff;
                     step_in  = i2cmrw_pkg::STEP_ADDRESS;
                     enter_ph = i2cmrw_pkg::PH_PRE;
                  end
               end else if (step_ff == i2cmrw_pkg::STEP_ADDRESS && data_ff != '0) begin
                  shift_in = data_ff;
                  step_in  = i2cmrw_pkg::STEP_DATA;
                  enter_ph = i2cmrw_pkg::PH_PRE;
               end else begin
                  enter_ph = i2cmrw_pkg::PH_SA;
               end
            end
            i2cmrw_pkg::PH_SA: enter_ph = i2cmrw_pkg::PH_SB;
            i2cmrw_pkg::PH_SB: enter_ph = i2cmrw_pkg::PH_SC;
            i2cmrw_pkg::PH_SC: enter_ph = i2cmrw_pkg::PH_SD;
            i2cmrw_pkg::PH_SD, i2cmrw_pkg::PH_RINIT: begin
               if (phase_ff == i2cmrw_pkg::PH_SD &&
                   step_ff != i2cmrw_pkg::STEP_RECOVERY) begin
                  enter_en = 1'b0;
                  done     = 1'b1;
               end else begin
                  round_in = (phase_ff == i2cmrw_pkg::PH_SD) ? round_ff + 4'd1 : 4'd0;
                  if (round_in >= ROUNDS) begin
                     enter_en  = 1'b0;
                     done      = 1'b1;
                     status_in = i2cmrw_pkg::STATUS_OK;
                  end else begin
                     enter_ph = sda ? i2cmrw_pkg::PH_RGAP : i2cmrw_pkg::PH_RLOW;
                  end
               end
            end
            i2cmrw_pkg::PH_RLOW:  enter_ph = i2cmrw_pkg::PH_RHIGH;
            i2cmrw_pkg::PH_RHIGH: enter_ph = i2cmrw_pkg::PH_RGAP;
            i2cmrw_pkg::PH_RGAP:  enter_ph = i2cmrw_pkg::PH_SA;
            default: begin
               enter_en  = 1'b0;
               done      = 1'b1;
               status_in = i2cmrw_pkg::STATUS_OK;
            end
         endcase
         if (done) begin
            phase_in       = i2cmrw_pkg::PH_IDLE;
            units_in       = '0;
            delay_count_in = '0;
         end
      end

      if (enter_en) begin
         phase_in       = enter_ph;
         units_in       = i2cmrw_pkg::UNITS_ONE;
         delay_count_in = unit_len;
         unique case (enter_ph)
            i2cmrw_pkg::PH_CHK1, i2cmrw_pkg::PH_RINIT: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
            i2cmrw_pkg::PH_CHK2: sda_in = 1'b0;
            i2cmrw_pkg::PH_HOLD: begin
               sda_in   = 1'b0;
               units_in = i2cmrw_pkg::UNITS_FOUR;
            end
            i2cmrw_pkg::PH_PRE: units_in = i2cmrw_pkg::UNITS_TWO;
            i2cmrw_pkg::PH_BDATA: begin
               sda_in   = shift_in[7];
               shift_in = {shift_in[6:0], 1'b0};
            end
            i2cmrw_pkg::PH_BLOW, i2cmrw_pkg::PH_ALOW, i2cmrw_pkg::PH_SA,
            i2cmrw_pkg::PH_RLOW: scl_in = 1'b0;
            i2cmrw_pkg::PH_BHIGH, i2cmrw_pkg::PH_AHIGH, i2cmrw_pkg::PH_SC,
            i2cmrw_pkg::PH_RHIGH: scl_in = 1'b1;
            i2cmrw_pkg::PH_AREL: sda_in = 1'b1;
            i2cmrw_pkg::PH_ATAIL: begin
               scl_in   = 1'b0;
               units_in = i2cmrw_pkg::UNITS_THREE;
            end
            i2cmrw_pkg::PH_SB: sda_in = 1'b0;
            i2cmrw_pkg::PH_SD: begin
               sda_in   = 1'b1;
               units_in = i2cmrw_pkg::UNITS_THREE;
            end
            default: ;
         endcase
      end

      out_word_in.scl_out  = scl_in;
      out_word_in.sda_out  = sda_in;
      out_word_in.busy_res = (phase_in != i2cmrw_pkg::PH_IDLE);
      out_word_in.done_res = done;
      out_word_in.status   = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= i2cmrw_pkg::PH_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         step_ff        <= i2cmrw_pkg::STEP_TARGET;
         delay_count_ff <= '0;
         units_ff       <= '0;
         address_ff     <= '0;
         data_ff        <= '0;
         round_ff       <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         status_ff      <= i2cmrw_pkg::STATUS_OK;
         out_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff       <= phase_in;
            bit_count_ff   <= bit_count_in;
            shift_ff       <= shift_in;
            step_ff        <= step_in;
            delay_count_ff <= delay_count_in;
            units_ff       <= units_in;
            address_ff     <= address_in;
            data_ff        <= data_in;
            round_ff       <= round_in;
            scl_ff         <= scl_in;
            sda_ff         <= sda_in;
            status_ff      <= status_in;
            out_valid_ff   <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= i2cmrw_pkg::DELAY_TICKS_RESET;
      end else if (csr_write) begin
         delay_ticks_ff <= csr_delay_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

/* src/i2c_master_register_write_top.sv */
`timescale 1ns / 1ps

// bit-banged i2c register write master stepped by timer ticks: every req word
// is one tick and gives exactly one rsp word with the scl/sda drive levels,
// busy, done and status. a new word is taken every clock while the result
// side keeps up, so the sustained rate is one word per cycle. a word is first
// written into the front queue, then the sequencer steps on it and registers
// the result, which then shows on rsp. a queue of QUEUE_DEPTH words sits
// between the front and the sequencer and absorbs rsp stalls. delay_ticks is
// written over the csr port; the user must write it only while the sequencer
// is idle, as the block itself does not enforce it.
module i2c_master_register_write_top #(
   parameter int RECOVERY_ROUNDS = 9,
   parameter int QUEUE_DEPTH     = 2
) (
   input  logic         clock,
   input  logic         reset,
   i2cmrw_req_if.sink   req_bus,
   i2cmrw_rsp_if.source rsp_bus,
   i2cmrw_csr_if.sink   csr_bus
);

   logic                   push_valid, push_ready;
   logic                   pop_valid, pop_ready;
   i2cmrw_pkg::entry_type  push_entry, pop_entry;
   i2cmrw_pkg::result_type out_word;

   assign csr_bus.ready = 1'b1;

   i2cmrw_front u_front (
      .req_bus    (req_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   i2cmrw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   i2cmrw_back #(
      .RECOVERY_ROUNDS (RECOVERY_ROUNDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_bus.valid),
      .csr_delay_ticks (csr_bus.delay_ticks),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .out_valid       (rsp_bus.valid),
      .out_ready       (rsp_bus.ready),
      .out_word        (out_word)
   );

   assign rsp_bus.scl_out  = out_word.scl_out;
   assign rsp_bus.sda_out  = out_word.sda_out;
   assign rsp_bus.busy_res = out_word.busy_res;
   assign rsp_bus.done_res = out_word.done_res;
   assign rsp_bus.status   = out_word.status;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.done_res |-> !rsp_bus.busy_res)
      else $error("done with busy set");

   a_start_fail_scl_high: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.done_res &&
      (rsp_bus.status == i2cmrw_pkg::STATUS_STUCK_LOW ||
       rsp_bus.status == i2cmrw_pkg::STATUS_NO_LOW) |-> rsp_bus.scl_out)
      else $error("start check failure with scl low");

   a_word_queued: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> pop_valid)
      else $error("accepted word missing from queue");

endmodule
